@@ rtl/core/dfdi_pkg.sv @@
// ----------------------------------------------------------------------------
// dfdi_pkg
// Shared constants, types and helpers of the disc flight integrator.
// ----------------------------------------------------------------------------
package dfdi_pkg;

   localparam int FracBits = 16;
   localparam int DtBits   = 16;
   localparam int RootSteps = 32;

   localparam logic [2:0] REG_DRAG_COEFF   = 3'd0;
   localparam logic [2:0] REG_LIFT_COEFF   = 3'd1;
   localparam logic [2:0] REG_FRONTAL_AREA = 3'd2;
   localparam logic [2:0] REG_INV_MASS     = 3'd3;
   localparam logic [2:0] REG_LIFT_PRODUCT = 3'd4;
   localparam logic [2:0] REG_WIND_X       = 3'd5;
   localparam logic [2:0] REG_WIND_Y       = 3'd6;
   localparam logic [2:0] REG_WIND_Z       = 3'd7;

   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_LAUNCH = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_SQSUM = 10'b0000000010,
      ST_ROOT  = 10'b0000000100,
      ST_COEF  = 10'b0000001000,
      ST_AXIS  = 10'b0000010000,
      ST_LIFT  = 10'b0000100000,
      ST_DONE  = 10'b0001000000,
      ST_OUT   = 10'b0010000000,
      ST_SPARE = 10'b0100000000,
      ST_HOLD  = 10'b1000000000
   } state_type;

   function automatic logic signed [31:0] clip32(input logic signed [65:0] v,
                                                 output logic sat);
      begin
         sat = 1'b0;
         if (v > 66'sd2147483647) begin
            sat = 1'b1;
            clip32 = 32'sh7fffffff;
         end else if (v < -66'sd2147483648) begin
            sat = 1'b1;
            clip32 = 32'sh80000000;
         end else begin
            clip32 = v[31:0];
         end
      end
   endfunction

endpackage

@@ rtl/core/disc_flight_drag_integrator_core.sv @@
// ----------------------------------------------------------------------------
// disc_flight_drag_integrator_core
// Fixed point flight step of a disc with quadratic drag, wind and lift.
// A launch beat offers its result beat in the cycle after acceptance. A tick
// beat computes the squares, a square root one bit per cycle, then products
// through one shared 33x33 multiplier with a register after it, before it
// offers its result beat. One beat is in work at a time, and a stalled result
// beat holds off the next beat.
// Synchronous reset clears the state vectors and loads the register defaults.
// ----------------------------------------------------------------------------
module disc_flight_drag_integrator_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [15:0]         req_time_step,
   input  logic signed [31:0]  req_load_pos_x,
   input  logic signed [31:0]  req_load_pos_y,
   input  logic signed [31:0]  req_load_pos_z,
   input  logic signed [31:0]  req_load_vel_x,
   input  logic signed [31:0]  req_load_vel_y,
   input  logic signed [31:0]  req_load_vel_z,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_out_pos_x,
   output logic signed [31:0]  rsp_out_pos_y,
   output logic signed [31:0]  rsp_out_pos_z,
   output logic signed [31:0]  rsp_out_vel_x,
   output logic signed [31:0]  rsp_out_vel_y,
   output logic signed [31:0]  rsp_out_vel_z,
   output logic                rsp_saturated
);

   dfdi_pkg::state_type state_ff, state_in;

   logic [30:0] drag_ff, lift_ff, area_ff, imass_ff;
   logic signed [31:0] lprod_ff;
   logic signed [31:0] wind_ff [3];
   logic signed [31:0] pos_ff [3], pos_in [3];
   logic signed [31:0] vel_ff [3], vel_in [3];
   logic signed [31:0] vnew_ff [3], vnew_in [3];
   logic [15:0] dt_ff, dt_in;
   logic sat_ff, sat_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [5:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic signed [31:0] ks_ff, ks_in, acc_ff, acc_in;
   logic signed [32:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [65:0] prod_ff;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [65:0] pshift, sum;
   logic signed [31:0] cv, cs;
   logic s1, s2;

   always_ff @(posedge clock) begin
      prod_ff <= ma_ff * mb_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drag_ff <= '0; lift_ff <= '0; area_ff <= '0; imass_ff <= 31'd65536;
         lprod_ff <= '0;
         wind_ff[0] <= '0; wind_ff[1] <= '0; wind_ff[2] <= '0;
      end else if (csr_write) begin
         case (csr_index)
            dfdi_pkg::REG_DRAG_COEFF:   drag_ff  <= csr_data[30:0];
            dfdi_pkg::REG_LIFT_COEFF:   lift_ff  <= csr_data[30:0];
            dfdi_pkg::REG_FRONTAL_AREA: area_ff  <= csr_data[30:0];
            dfdi_pkg::REG_INV_MASS:     imass_ff <= csr_data[30:0];
            dfdi_pkg::REG_LIFT_PRODUCT: lprod_ff <= csr_data;
            dfdi_pkg::REG_WIND_X:       wind_ff[0] <= csr_data;
            dfdi_pkg::REG_WIND_Y:       wind_ff[1] <= csr_data;
            dfdi_pkg::REG_WIND_Z:       wind_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dfdi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff <= pos_in;
         vel_ff <= vel_in;
      end
      vnew_ff <= vnew_in; dt_ff <= dt_in; sat_ff <= sat_in;
      rem_ff <= rem_in; root_ff <= root_in; cnt_ff <= cnt_in;
      axis_ff <= axis_in; ks_ff <= ks_in; acc_ff <= acc_in;
      ma_ff <= ma_in; mb_ff <= mb_in;
   end

   // Product floor-shifted by the fraction width (arithmetic shift is floor).
   assign pshift = prod_ff >>> dfdi_pkg::FracBits;

   always_comb begin
      logic [63:0] sq;
      state_in = state_ff; rsp_valid_in = rsp_valid_ff;
      pos_in = pos_ff; vel_in = vel_ff; vnew_in = vnew_ff;
      dt_in = dt_ff; sat_in = sat_ff; rem_in = rem_ff; root_in = root_ff;
      cnt_in = cnt_ff; axis_in = axis_ff;
      ks_in = ks_ff; acc_in = acc_ff; ma_in = ma_ff; mb_in = mb_ff;
      sum = '0; cv = '0; cs = '0; s1 = 1'b0; s2 = 1'b0; sq = '0;
      case (state_ff)
         dfdi_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == dfdi_pkg::REQ_LAUNCH) begin
                  pos_in[0] = req_load_pos_x; pos_in[1] = req_load_pos_y;
                  pos_in[2] = req_load_pos_z;
                  vel_in[0] = req_load_vel_x; vel_in[1] = req_load_vel_y;
                  vel_in[2] = req_load_vel_z;
                  sat_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in = dfdi_pkg::ST_OUT;
               end else begin
                  dt_in = req_time_step;
                  sat_in = 1'b0;
                  rem_in = '0;
                  cnt_in = '0;
                  ma_in = 33'(vel_ff[0]); mb_in = 33'(vel_ff[0]);
                  state_in = dfdi_pkg::ST_SQSUM;
               end
            end
         end
         dfdi_pkg::ST_SQSUM: begin
            // cnt 0: issue y, 1: add x issue z, 2: add y, 3: add z
            if (cnt_ff != 6'd0) rem_in = rem_ff + prod_ff[63:0];
            if (cnt_ff == 6'd0) begin ma_in = 33'(vel_ff[1]); mb_in = 33'(vel_ff[1]); end
            if (cnt_ff == 6'd1) begin ma_in = 33'(vel_ff[2]); mb_in = 33'(vel_ff[2]); end
            if (cnt_ff == 6'd0) rem_in = '0;
            if (cnt_ff == 6'd0) begin
               cnt_in = 6'd1;
            end else if (cnt_ff == 6'd3) begin
               cnt_in = '0;
               root_in = '0;
               acc_in = '0;
               state_in = dfdi_pkg::ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         dfdi_pkg::ST_ROOT: begin
            // Restoring root: acc_ff holds the partial remainder, root_ff the partial root.
            sq = rem_ff;
            begin
               logic [33:0] r2;
               logic [33:0] tr;
               r2 = {acc_ff[31:0], sq[63:62]};
               tr = r2 - {root_ff[31:0], 2'b01};
               if (!tr[33]) begin
                  acc_in = tr[31:0];
                  root_in = {root_ff[30:0], 1'b1};
               end else begin
                  acc_in = r2[31:0];
                  root_in = {root_ff[30:0], 1'b0};
               end
               if (!tr[33] && tr[33:32] != 2'b00) acc_in = tr[31:0];
               ks_in = ks_ff;
            end
            rem_in = {rem_ff[61:0], 2'b00};
            if (cnt_ff == 6'(dfdi_pkg::RootSteps - 1)) begin
               cnt_in = '0;
               state_in = dfdi_pkg::ST_COEF;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         dfdi_pkg::ST_COEF: begin
            // 0 issue Cd*A, 2 take kd issue kd*speed, 4 take ks
            case (cnt_ff)
               6'd0: begin
                  if (root_ff[31]) begin sat_in = 1'b1; root_in = 32'h7fffffff; end
                  ma_in = 33'(drag_ff); mb_in = 33'(area_ff);
               end
               6'd2: begin
                  sq = prod_ff[63:0] >> (dfdi_pkg::FracBits + 1);
                  if (sq > 64'h7fffffff) begin sat_in = 1'b1; sq = 64'h7fffffff; end
                  ma_in = 33'(sq[31:0]); mb_in = 33'(root_ff);
               end
               6'd4: begin
                  ks_in = dfdi_pkg::clip32(pshift, s1);
                  sat_in = sat_ff | s1;
               end
               default: ;
            endcase
            if (cnt_ff == 6'd4) begin
               cnt_in = '0; axis_in = '0; state_in = dfdi_pkg::ST_AXIS;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         dfdi_pkg::ST_AXIS: begin
            case (cnt_ff)
               6'd0: begin
                  ma_in = -$signed({ks_ff[31], ks_ff}); mb_in = 33'(vel_ff[axis_ff]);
               end
               6'd2: begin
                  cv = dfdi_pkg::clip32(pshift, s1);
                  sum = 66'(cv) + 66'(wind_ff[axis_ff]);
                  cs = dfdi_pkg::clip32(sum, s2);
                  sat_in = sat_ff | s1 | s2;
                  ma_in = 33'(cs); mb_in = 33'(imass_ff);
               end
               6'd4: begin
                  cv = dfdi_pkg::clip32(pshift, s1);
                  sat_in = sat_ff | s1;
                  ma_in = 33'(cv); mb_in = 33'(dt_ff);
               end
               6'd6: begin
                  cv = dfdi_pkg::clip32(prod_ff >>> dfdi_pkg::DtBits, s1);
                  sum = 66'(vel_ff[axis_ff]) + 66'(cv);
                  cs = dfdi_pkg::clip32(sum, s2);
                  sat_in = sat_ff | s1 | s2;
                  vnew_in[axis_ff] = cs;
                  sum = 66'(vel_ff[axis_ff]) + 66'(cs);
                  ma_in = sum[32:0]; mb_in = 33'(dt_ff);
               end
               6'd8: begin
                  sum = 66'(pos_ff[axis_ff]) + (prod_ff >>> (dfdi_pkg::DtBits + 1));
                  cs = dfdi_pkg::clip32(sum, s1);
                  sat_in = sat_ff | s1;
                  pos_in[axis_ff] = cs;
               end
               default: ;
            endcase
            if (cnt_ff == 6'd8) begin
               cnt_in = '0;
               if (axis_ff == 2'd2) state_in = dfdi_pkg::ST_LIFT;
               else axis_in = axis_ff + 2'd1;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         dfdi_pkg::ST_LIFT: begin
            case (cnt_ff)
               6'd0: begin ma_in = 33'(lift_ff); mb_in = 33'(area_ff); end
               6'd2: begin
                  sq = prod_ff[63:0] >> (dfdi_pkg::FracBits + 1);
                  if (sq > 64'h7fffffff) begin sat_in = 1'b1; sq = 64'h7fffffff; end
                  ma_in = 33'(sq[31:0]); mb_in = 33'(lprod_ff);
               end
               6'd4: begin
                  cv = dfdi_pkg::clip32(pshift, s1);
                  sat_in = sat_ff | s1;
                  ma_in = 33'(cv); mb_in = 33'(imass_ff);
               end
               6'd6: begin
                  cv = dfdi_pkg::clip32(pshift, s1);
                  sat_in = sat_ff | s1;
                  ma_in = 33'(cv); mb_in = 33'(dt_ff);
               end
               6'd8: begin
                  cv = dfdi_pkg::clip32(prod_ff >>> dfdi_pkg::DtBits, s1);
                  sum = 66'(vnew_ff[2]) + 66'(cv);
                  cs = dfdi_pkg::clip32(sum, s2);
                  sat_in = sat_ff | s1 | s2;
                  vel_in[0] = vnew_ff[0]; vel_in[1] = vnew_ff[1]; vel_in[2] = cs;
               end
               default: ;
            endcase
            if (cnt_ff == 6'd8) begin
               cnt_in = '0; rsp_valid_in = 1'b1; state_in = dfdi_pkg::ST_OUT;
            end else begin
               cnt_in = cnt_ff + 6'd1;
            end
         end
         dfdi_pkg::ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = dfdi_pkg::ST_IDLE;
            end
         end
         default: state_in = dfdi_pkg::ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != dfdi_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_pos_x = pos_ff[0];
   assign rsp_out_pos_y = pos_ff[1];
   assign rsp_out_pos_z = pos_ff[2];
   assign rsp_out_vel_x = vel_ff[0];
   assign rsp_out_vel_y = vel_ff[1];
   assign rsp_out_vel_z = vel_ff[2];
   assign rsp_saturated = sat_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives launch and tick beats into the disc flight integrator, predicts each
// result beat with its own fixed point flight step and compares every field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [31:0] px, py, pz, vx, vy, vz;
      logic               sat;
   } flight_state_type;

   logic clock, reset;
   logic csr_write;
   logic [2:0] csr_index;
   logic [31:0] csr_data;
   logic req_valid, req_stall, req_type;
   logic [15:0] req_time_step;
   logic signed [31:0] req_load_pos_x, req_load_pos_y, req_load_pos_z;
   logic signed [31:0] req_load_vel_x, req_load_vel_y, req_load_vel_z;
   logic rsp_valid, rsp_stall;
   logic signed [31:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic signed [31:0] rsp_out_vel_x, rsp_out_vel_y, rsp_out_vel_z;
   logic rsp_saturated;

   disc_flight_drag_integrator_core dut (.*);

   flight_state_type pending_flight[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit long_hold = 0;
   bit bursty = 1;

   longint drag_c, lift_c, area_c, inv_m, lift_p;
   longint wind[3];
   longint pos[3], vel[3];

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic longint sat32(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint fshift(longint p, int sh);
      return p >>> sh;
   endfunction

   function automatic longint fmul(longint a, longint b, int sh, inout bit sat);
      return sat32(fshift(a * b, sh), sat);
   endfunction

   function automatic longint root64(logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint half_coef(longint c, longint a, inout bit sat);
      logic [63:0] p;
      p = (64'(c) * 64'(a)) >> (dfdi_pkg::FracBits + 1);
      if (p > 64'd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      return longint'(p);
   endfunction

   function automatic flight_state_type flight_step(logic typ, logic [15:0] ts,
                                                    logic signed [31:0] lp[3],
                                                    logic signed [31:0] lv[3]);
      flight_state_type r;
      bit sat;
      longint dt, speed, kd, ks, kl, lift, lacc, drag, fsum, acc, dv, dp;
      longint vnew[3];
      logic [63:0] s2, m;
      sat = 0;
      if (typ == dfdi_pkg::REQ_LAUNCH) begin
         for (int i = 0; i < 3; i++) begin
            pos[i] = longint'(lp[i]);
            vel[i] = longint'(lv[i]);
         end
      end else begin
         dt = longint'(ts);
         s2 = 0;
         for (int i = 0; i < 3; i++) begin
            m = vel[i] < 0 ? -vel[i] : vel[i];
            s2 = s2 + m * m;
         end
         speed = sat32(root64(s2), sat);
         kd = half_coef(drag_c, area_c, sat);
         ks = fmul(kd, speed, dfdi_pkg::FracBits, sat);
         for (int i = 0; i < 3; i++) begin
            drag = fmul(-ks, vel[i], dfdi_pkg::FracBits, sat);
            fsum = sat32(drag + wind[i], sat);
            acc = fmul(fsum, inv_m, dfdi_pkg::FracBits, sat);
            dv = fmul(acc, dt, dfdi_pkg::DtBits, sat);
            vnew[i] = sat32(vel[i] + dv, sat);
            dp = fshift((vel[i] + vnew[i]) * dt, dfdi_pkg::DtBits + 1);
            pos[i] = sat32(pos[i] + dp, sat);
         end
         kl = half_coef(lift_c, area_c, sat);
         lift = fmul(kl, lift_p, dfdi_pkg::FracBits, sat);
         lacc = fmul(lift, inv_m, dfdi_pkg::FracBits, sat);
         vnew[2] = sat32(vnew[2] + fmul(lacc, dt, dfdi_pkg::DtBits, sat), sat);
         for (int i = 0; i < 3; i++) vel[i] = vnew[i];
      end
      r.px = 32'(pos[0]); r.py = 32'(pos[1]); r.pz = 32'(pos[2]);
      r.vx = 32'(vel[0]); r.vy = 32'(vel[1]); r.vz = 32'(vel[2]);
      r.sat = sat;
      return r;
   endfunction

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         dfdi_pkg::REG_DRAG_COEFF:   drag_c = longint'(val[30:0]);
         dfdi_pkg::REG_LIFT_COEFF:   lift_c = longint'(val[30:0]);
         dfdi_pkg::REG_FRONTAL_AREA: area_c = longint'(val[30:0]);
         dfdi_pkg::REG_INV_MASS:     inv_m = longint'(val[30:0]);
         dfdi_pkg::REG_LIFT_PRODUCT: lift_p = longint'($signed(val));
         dfdi_pkg::REG_WIND_X:       wind[0] = longint'($signed(val));
         dfdi_pkg::REG_WIND_Y:       wind[1] = longint'($signed(val));
         dfdi_pkg::REG_WIND_Z:       wind[2] = longint'($signed(val));
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic send_beat(logic typ, logic [15:0] ts, logic signed [31:0] lp[3],
                            logic signed [31:0] lv[3]);
      if (bursty && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= typ;
      req_time_step <= ts;
      req_load_pos_x <= lp[0]; req_load_pos_y <= lp[1]; req_load_pos_z <= lp[2];
      req_load_vel_x <= lv[0]; req_load_vel_y <= lv[1]; req_load_vel_z <= lv[2];
      do @(posedge clock); while (req_stall);
      pending_flight.push_back(flight_step(typ, ts, lp, lv));
   endtask

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h000fffff);
         3: return -$urandom_range(0, 32'h000fffff);
         default: return $urandom;
      endcase
   endfunction

   task automatic launch(logic signed [31:0] p0, p1, p2, v0, v1, v2);
      logic signed [31:0] lp[3];
      logic signed [31:0] lv[3];
      lp = '{p0, p1, p2};
      lv = '{v0, v1, v2};
      send_beat(dfdi_pkg::REQ_LAUNCH, 16'($urandom), lp, lv);
   endtask

   task automatic tick(logic [15:0] ts);
      logic signed [31:0] lp[3];
      logic signed [31:0] lv[3];
      lp = '{$urandom, $urandom, $urandom};
      lv = '{$urandom, $urandom, $urandom};
      send_beat(dfdi_pkg::REQ_TICK, ts, lp, lv);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_flight.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic realistic_regs();
      write_reg(dfdi_pkg::REG_DRAG_COEFF, 32'h00001400 + $urandom_range(0, 32'h1000));
      write_reg(dfdi_pkg::REG_LIFT_COEFF, 32'h00002000 + $urandom_range(0, 32'h4000));
      write_reg(dfdi_pkg::REG_FRONTAL_AREA, 32'h00001000 + $urandom_range(0, 32'h1000));
      write_reg(dfdi_pkg::REG_INV_MASS, 32'h00060000 + $urandom_range(0, 32'h10000));
      write_reg(dfdi_pkg::REG_LIFT_PRODUCT, 32'h00090000 + $urandom_range(0, 32'h10000));
      write_reg(dfdi_pkg::REG_WIND_X, $urandom_range(0, 32'h20000) - 32'h10000);
      write_reg(dfdi_pkg::REG_WIND_Y, $urandom_range(0, 32'h20000) - 32'h10000);
      write_reg(dfdi_pkg::REG_WIND_Z, $urandom_range(0, 32'h20000) - 32'h10000);
   endtask

   task automatic test_default_regs();
      launch(0, 0, 0, 0, 0, 0);
      tick(16'hffff);
      launch(32'sh7fffffff, 32'sh80000000, 1, 32'sh7fffffff, 32'sh7fffffff,
             32'sh7fffffff);
      tick(16'hffff);
      tick(0);
      launch(-1, 0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000);
      tick(16'h8000);
      drain();
   endtask

   task automatic test_flight();
      realistic_regs();
      launch(0, 0, 32'h00010000, 32'h000e0000, 0, 32'h00020000);
      repeat (8) tick(16'h0444);
      launch(0, 0, 0, 0, 0, 0);
      tick(16'h1000);
      drain();
   endtask

   task automatic test_extreme_regs();
      for (int i = 0; i < 8; i++) write_reg(3'(i), (i >= 4) ? 32'h80000000 : 32'h7fffffff);
      launch(1, -1, 0, 32'h00010000, -32'sh00010000, 32'h7fffffff);
      tick(16'hffff);
      tick(16'h0001);
      drain();
      for (int i = 0; i < 8; i++) write_reg(3'(i), (i >= 4) ? 32'h7fffffff : 0);
      tick(16'hffff);
      drain();
   endtask

   task automatic test_random_flights();
      for (int phase = 0; phase < 6; phase++) begin
         if (phase % 3 == 2) begin
            for (int i = 0; i < 8; i++) write_reg(3'(i), rand_word());
         end else begin
            realistic_regs();
         end
         bursty = (phase != 1);
         for (int n = 0; n < 65; n++) begin
            if ($urandom_range(0, 9) == 0) begin
               launch(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word());
            end else if ($urandom_range(0, 6) == 0) begin
               tick(16'($urandom));
            end else begin
               tick(16'($urandom_range(0, 16'h2000)));
            end
         end
         drain();
      end
      bursty = 1;
   endtask

   task automatic test_backpressure();
      long_hold = 1;
      repeat (5) tick(16'($urandom_range(0, 16'h1000)));
      long_hold = 0;
      drain();
   endtask

   initial begin
      rsp_stall = 1;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            rsp_stall <= 0;
            wait (!long_hold);
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < (($urandom_range(0, 7) == 0) ? 80 : 15));
         end
      end
   end

   always @(posedge clock) begin
      flight_state_type exp_r, got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z, rsp_out_vel_x,
                 rsp_out_vel_y, rsp_out_vel_z, rsp_saturated};
         if (pending_flight.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result beat %p", got);
         end else begin
            exp_r = pending_flight.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10) $display("Mismatch: expected %p actual %p", exp_r, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      reset <= 1;
      csr_write <= 0; csr_index <= 0; csr_data <= 0;
      req_valid <= 0; req_type <= 0; req_time_step <= 0;
      req_load_pos_x <= 0; req_load_pos_y <= 0; req_load_pos_z <= 0;
      req_load_vel_x <= 0; req_load_vel_y <= 0; req_load_vel_z <= 0;
      drag_c = 0; lift_c = 0; area_c = 0; inv_m = 65536; lift_p = 0;
      for (int i = 0; i < 3; i++) begin
         wind[i] = 0; pos[i] = 0; vel[i] = 0;
      end
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_default_regs();
      test_flight();
      test_extreme_regs();
      test_backpressure();
      test_random_flights();
      if (mismatches == 0 && pending_flight.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
